// File: sv/plob_pkg.sv
// plob_pkg: shared types, codes and constants of the price-level order book
// no dependencies; imported by plob_cell, plob_row and price_level_order_book
package plob_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int PRICE_W       = 63;
    localparam int QTY_W         = 63;
    localparam int COUNT_W       = 7;
    localparam int SPREAD_W      = 64;

    typedef enum logic [2:0] {
        STAT_UPDATED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_REMOVED  = 3'd2,
        STAT_NOCHANGE = 3'd3,
        STAT_EVICTED  = 3'd4,
        STAT_DROPPED  = 3'd5,
        STAT_CLEARED  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_UPD,
        FSM_OUT
    } fsm_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_OVERWRITE,
        MODE_REMOVE,
        MODE_INSERT
    } cell_mode_t;

    localparam logic ACTION_APPLY = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;
    localparam logic SIDE_BID     = 1'b0;
    localparam logic SIDE_ASK     = 1'b1;

    typedef struct packed {
        logic               action;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } upd_t;

    typedef struct packed {
        status_t                    status;
        logic [PRICE_W-1:0]         best_bid_price;
        logic [QTY_W-1:0]           best_bid_quantity;
        logic [PRICE_W-1:0]         best_ask_price;
        logic [QTY_W-1:0]           best_ask_quantity;
        logic signed [SPREAD_W-1:0] price_spread;
        logic [COUNT_W-1:0]         bid_level_count;
        logic [COUNT_W-1:0]         ask_level_count;
    } book_t;

    typedef struct packed {
        logic               cmp_en;
        logic               update_en;
        cell_mode_t         mode;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } row_cmd_t;

    typedef struct packed {
        logic               found;
        logic               last_better;
        logic [PRICE_W-1:0] head_price;
        logic [QTY_W-1:0]   head_quantity;
    } row_stat_t;

endpackage

// File: sv/price_level_order_book.sv
// price_level_order_book: bid and ask level tables with best-level report
// sequence: the accepted beat is registered, the update state applies it, the output state registers the result
// a new beat is taken only once the cells have compared and shifted and the previous result is loaded
// reset: both fill counts clear at once, cell contents stay undefined until written
// depends on plob_pkg and plob_row
module price_level_order_book
    import plob_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  upd_valid,
    output logic  upd_ready,
    input  upd_t  upd,
    output logic  book_valid,
    input  logic  book_ready,
    output book_t book
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    fsm_t               state_reg, state_next;
    upd_t               item_reg, item_next;
    status_t            status_reg, status_next;
    logic [FILL_W-1:0]  bid_fill_reg, bid_fill_next;
    logic [FILL_W-1:0]  ask_fill_reg, ask_fill_next;
    logic               book_valid_reg, book_valid_next;
    book_t              book_reg, book_next;

    row_cmd_t           bid_cmd, ask_cmd;
    row_stat_t          bid_stat, ask_stat;
    row_stat_t          side_stat;
    logic [FILL_W-1:0]  side_fill;
    cell_mode_t         mode;
    logic [FILL_W-1:0]  side_fill_new;

    logic upd_fire;
    logic out_free;
    logic out_load;
    logic cmp_en;
    logic apply_en;

    assign out_free = !book_valid_reg || book_ready;
    assign upd_fire = upd_valid && upd_ready;

    plob_row #(
        .DEPTH (DEPTH),
        .DESC  (1'b1)
    ) u_bid (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bid_cmd),
        .fill  (bid_fill_reg),
        .stat  (bid_stat)
    );

    plob_row #(
        .DEPTH (DEPTH),
        .DESC  (1'b0)
    ) u_ask (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ask_cmd),
        .fill  (ask_fill_reg),
        .stat  (ask_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (upd_valid)
                begin
                    state_next = FSM_UPD;
                end
            end
            FSM_UPD:
            begin
                state_next = FSM_OUT;
            end
            FSM_OUT:
            begin
                if (out_free)
                begin
                    state_next = upd_valid ? FSM_UPD : FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        upd_ready = 1'b0;
        out_load  = 1'b0;
        apply_en  = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                upd_ready = 1'b1;
            end
            FSM_UPD:
            begin
                apply_en = 1'b1;
            end
            FSM_OUT:
            begin
                upd_ready = out_free;
                out_load  = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign cmp_en = upd_fire;

    // update decision for the addressed side
    assign side_stat = (item_reg.side == SIDE_ASK) ? ask_stat : bid_stat;
    assign side_fill = (item_reg.side == SIDE_ASK) ? ask_fill_reg : bid_fill_reg;

    always_comb
    begin
        mode          = MODE_NONE;
        status_next   = status_reg;
        side_fill_new = side_fill;
        if (item_reg.action == ACTION_CLEAR)
        begin
            status_next = STAT_CLEARED;
        end
        else if (side_stat.found && (item_reg.quantity == '0))
        begin
            mode          = MODE_REMOVE;
            status_next   = STAT_REMOVED;
            side_fill_new = side_fill - FILL_W'(1);
        end
        else if (side_stat.found)
        begin
            mode        = MODE_OVERWRITE;
            status_next = STAT_UPDATED;
        end
        else if (item_reg.quantity == '0)
        begin
            status_next = STAT_NOCHANGE;
        end
        else if (side_fill == FILL_W'(DEPTH))
        begin
            if (side_stat.last_better)
            begin
                status_next = STAT_DROPPED;
            end
            else
            begin
                mode        = MODE_INSERT;
                status_next = STAT_EVICTED;
            end
        end
        else
        begin
            mode          = MODE_INSERT;
            status_next   = STAT_INSERTED;
            side_fill_new = side_fill + FILL_W'(1);
        end
        if (!apply_en)
        begin
            status_next = status_reg;
        end
    end

    always_comb
    begin
        bid_fill_next = bid_fill_reg;
        ask_fill_next = ask_fill_reg;
        if (apply_en)
        begin
            if (item_reg.action == ACTION_CLEAR)
            begin
                bid_fill_next = '0;
                ask_fill_next = '0;
            end
            else if (item_reg.side == SIDE_ASK)
            begin
                ask_fill_next = side_fill_new;
            end
            else
            begin
                bid_fill_next = side_fill_new;
            end
        end
    end

    always_comb
    begin
        bid_cmd.cmp_en    = cmp_en;
        bid_cmd.update_en = apply_en && (item_reg.action == ACTION_APPLY) &&
                            (item_reg.side == SIDE_BID);
        bid_cmd.mode      = mode;
        bid_cmd.price     = cmp_en ? upd.price : item_reg.price;
        bid_cmd.quantity  = item_reg.quantity;
        ask_cmd           = bid_cmd;
        ask_cmd.update_en = apply_en && (item_reg.action == ACTION_APPLY) &&
                            (item_reg.side == SIDE_ASK);
    end

    assign item_next = upd_fire ? upd : item_reg;

    // result beat
    always_comb
    begin
        book_valid_next = book_valid_reg;
        book_next       = book_reg;
        if (book_valid_reg && book_ready)
        begin
            book_valid_next = 1'b0;
        end
        if (out_load)
        begin
            book_valid_next             = 1'b1;
            book_next.status            = status_reg;
            book_next.best_bid_price    = '0;
            book_next.best_bid_quantity = '0;
            book_next.best_ask_price    = '0;
            book_next.best_ask_quantity = '0;
            book_next.price_spread      = '0;
            if (bid_fill_reg != '0)
            begin
                book_next.best_bid_price    = bid_stat.head_price;
                book_next.best_bid_quantity = bid_stat.head_quantity;
            end
            if (ask_fill_reg != '0)
            begin
                book_next.best_ask_price    = ask_stat.head_price;
                book_next.best_ask_quantity = ask_stat.head_quantity;
            end
            if ((bid_fill_reg != '0) && (ask_fill_reg != '0))
            begin
                book_next.price_spread = SPREAD_W'({1'b0, ask_stat.head_price}) -
                                         SPREAD_W'({1'b0, bid_stat.head_price});
            end
            book_next.bid_level_count = COUNT_W'(bid_fill_reg);
            book_next.ask_level_count = COUNT_W'(ask_fill_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        book_reg <= book_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            status_reg     <= STAT_NOCHANGE;
            bid_fill_reg   <= '0;
            ask_fill_reg   <= '0;
            book_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            bid_fill_reg   <= bid_fill_next;
            ask_fill_reg   <= ask_fill_next;
            book_valid_reg <= book_valid_next;
        end
    end

    assign book_valid = book_valid_reg;
    assign book       = book_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (bid_fill_reg <= FILL_W'(DEPTH)) && (ask_fill_reg <= FILL_W'(DEPTH)))
        else $error("level count beyond depth");

    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> (state_reg == FSM_UPD))
        else $error("accepted beat not followed by update cycle");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_en && (item_reg.action == ACTION_CLEAR)) |=>
        ((bid_fill_reg == '0) && (ask_fill_reg == '0)))
        else $error("clear left levels behind");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (book_valid_reg && !book_ready) |=> (book_valid_reg && $stable(book_reg)))
        else $error("pending result overwritten");

endmodule

// File: sv/plob_cell.sv
// plob_cell: one price level of a sorted table, with compare flags
// depends on plob_pkg
module plob_cell
    import plob_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int INDEX = 0,
    parameter bit DESC  = 1'b1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  row_cmd_t                       cmd,
    input  logic [$clog2(DEPTH+1)-1:0]     fill,
    input  logic                           left_better,
    input  logic [PRICE_W-1:0]             left_price,
    input  logic [QTY_W-1:0]               left_quantity,
    input  logic [PRICE_W-1:0]             right_price,
    input  logic [QTY_W-1:0]               right_quantity,
    output logic [PRICE_W-1:0]             price,
    output logic [QTY_W-1:0]               quantity,
    output logic                           better,
    output logic                           match
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [PRICE_W-1:0] price_reg, price_next;
    logic [QTY_W-1:0]   quantity_reg, quantity_next;
    logic               better_reg, better_next;
    logic               match_reg, match_next;
    logic               level_valid;

    assign level_valid = fill > FILL_W'(INDEX);

    always_comb
    begin
        better_next = better_reg;
        match_next  = match_reg;
        if (cmd.cmp_en)
        begin
            if (DESC)
            begin
                better_next = level_valid && (price_reg > cmd.price);
            end
            else
            begin
                better_next = level_valid && (price_reg < cmd.price);
            end
            match_next = level_valid && (price_reg == cmd.price);
        end
    end

    always_comb
    begin
        price_next    = price_reg;
        quantity_next = quantity_reg;
        if (cmd.update_en)
        begin
            case (cmd.mode)
                MODE_OVERWRITE:
                begin
                    if (match_reg)
                    begin
                        quantity_next = cmd.quantity;
                    end
                end
                MODE_REMOVE:
                begin
                    if (!better_reg)
                    begin
                        price_next    = right_price;
                        quantity_next = right_quantity;
                    end
                end
                MODE_INSERT:
                begin
                    if (!better_reg)
                    begin
                        if (left_better)
                        begin
                            price_next    = cmd.price;
                            quantity_next = cmd.quantity;
                        end
                        else
                        begin
                            price_next    = left_price;
                            quantity_next = left_quantity;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        quantity_reg <= quantity_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            better_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            better_reg <= better_next;
            match_reg  <= match_next;
        end
    end

    assign price    = price_reg;
    assign quantity = quantity_reg;
    assign better   = better_reg;
    assign match    = match_reg;

endmodule

// File: sv/plob_row.sv
// plob_row: one side of the book as a chain of plob_cell levels
// depends on plob_pkg and plob_cell
module plob_row
    import plob_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter bit DESC  = 1'b1
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  row_cmd_t                   cmd,
    input  logic [$clog2(DEPTH+1)-1:0] fill,
    output row_stat_t                  stat
);

    logic [DEPTH-1:0]   better_w;
    logic [DEPTH-1:0]   match_w;
    logic [PRICE_W-1:0] price_w    [DEPTH];
    logic [QTY_W-1:0]   quantity_w [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic               lb;
        logic [PRICE_W-1:0] lp;
        logic [QTY_W-1:0]   lq;
        logic [PRICE_W-1:0] rp;
        logic [QTY_W-1:0]   rq;

        if (g == 0)
        begin : g_head
            assign lb = 1'b1;
            assign lp = '0;
            assign lq = '0;
        end
        else
        begin : g_body
            assign lb = better_w[g-1];
            assign lp = price_w[g-1];
            assign lq = quantity_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign rp = '0;
            assign rq = '0;
        end
        else
        begin : g_next
            assign rp = price_w[g+1];
            assign rq = quantity_w[g+1];
        end

        plob_cell #(
            .DEPTH (DEPTH),
            .INDEX (g),
            .DESC  (DESC)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .fill           (fill),
            .left_better    (lb),
            .left_price     (lp),
            .left_quantity  (lq),
            .right_price    (rp),
            .right_quantity (rq),
            .price          (price_w[g]),
            .quantity       (quantity_w[g]),
            .better         (better_w[g]),
            .match          (match_w[g])
        );
    end

    assign stat.found         = |match_w;
    assign stat.last_better   = better_w[DEPTH-1];
    assign stat.head_price    = price_w[0];
    assign stat.head_quantity = quantity_w[0];

endmodule
